/* hw/rtl/ppg_pkg.sv */
// Shared types, constants and arithmetic helpers for the plasma pixel generator.
// No dependencies; imported by the front, the back and the top level of the block.
package ppg_pkg;

    localparam int X_W     = 6;
    localparam int Y_W     = 4;
    localparam int STEP_W  = 16;
    localparam int SPEED_W = 16;
    localparam int TINT_W  = 24;
    localparam int PHASE_W = 32;
    localparam int CH_W    = 8;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_TINT  = 1'b1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd50;
    localparam logic [TINT_W-1:0]  TINT_RESET  = 24'hFF40FF;

    // queue depths (power of two, at least 2)
    localparam int JOB_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // long division by small constants, one byte of dividend per cycle
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = PHASE_W / DIGIT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W     = 6;

    localparam logic [REM_W-1:0] DIV_SPEED = 6'd50;
    localparam logic [REM_W-1:0] DIV_A     = 6'd9;
    localparam logic [REM_W-1:0] DIV_B     = 6'd14;
    localparam logic [REM_W-1:0] DIV_C     = 6'd6;

    // angle multipliers of the three waves
    localparam logic [7:0] MUL_X  = 8'd13;
    localparam logic [7:0] MUL_Y  = 8'd23;
    localparam logic [7:0] MUL_XY = 8'd11;

    localparam logic [7:0] WAVE_MID = 8'd128;
    localparam logic [6:0] WAVE_TOP = 7'd127;

    // sum / 3 == (sum * 683) >> 11 for sums below 768
    localparam logic [9:0] AVG_MUL   = 10'd683;
    localparam int         AVG_SHIFT = 11;

    typedef struct packed {
        logic [X_W-1:0]    pixel_x;
        logic [Y_W-1:0]    pixel_y;
        logic [STEP_W-1:0] step_ms;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel_out;

    typedef struct packed {
        logic [X_W-1:0]     pixel_x;
        logic [Y_W-1:0]     pixel_y;
        logic [PHASE_W-1:0] phase;
    } t_job;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [DIGIT_W-1:0] quo;
    } t_div;

    // one byte of restoring division; rem_in < divisor
    function automatic t_div div_byte(input logic [REM_W-1:0] rem_in,
                                      input logic [DIGIT_W-1:0] digits,
                                      input logic [REM_W-1:0] divisor);
        logic [REM_W:0] acc;
        t_div           res;
        acc = {1'b0, rem_in};
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            acc = {acc[REM_W-1:0], digits[i]};
            if (acc >= {1'b0, divisor}) begin
                acc        = acc - {1'b0, divisor};
                res.quo[i] = 1'b1;
            end else begin
                res.quo[i] = 1'b0;
            end
        end
        res.rem = acc[REM_W-1:0];
        return res;
    endfunction

    // parabolic wave, 2..254
    function automatic logic [7:0] wave_at(input logic [7:0] angle);
        logic [6:0]  h;
        logic [13:0] prod;
        logic [7:0]  hump;
        h    = angle[6:0];
        prod = {7'b0, h} * {7'b0, WAVE_TOP - h};
        hump = {1'b0, prod[11:5]};
        return angle[7] ? (WAVE_MID - hump) : (WAVE_MID + hump);
    endfunction

    // exact p / 255 for p < 65280
    function automatic logic [CH_W-1:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

/* hw/rtl/ppg_fifo.sv */
// Small first-word-fall-through queue used between front and back and at the output.
// Depends on nothing but its parameters.
module ppg_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr, r_rd;
    logic [AW:0]      n_wr, n_rd;
    logic             wr_en, rd_en;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd[AW-1:0]];

    assign n_wr = wr_en ? r_wr + 1'b1 : r_wr;
    assign n_rd = rd_en ? r_rd + 1'b1 : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

/* hw/rtl/ppg_front.sv */
// Front end: takes pixels, scales the time step by speed / 50 and advances the phase.
// Uses ppg_pkg; feeds jobs into the job queue.
module ppg_front
    import ppg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  t_pixel_in          i_item,
    input  logic [SPEED_W-1:0] i_speed,
    output logic               o_job_push,
    input  logic               i_job_full,
    output t_job               o_job
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [X_W-1:0]     r_x, n_x;
    logic [Y_W-1:0]     r_y, n_y;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [PHASE_W-1:0] r_work, n_work;
    logic [PHASE_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0]   r_rem, n_rem;
    t_div               dig;

    assign dig = div_byte(r_rem, r_work[PHASE_W-1 -: DIGIT_W], DIV_SPEED);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_x     = r_x;
        n_y     = r_y;
        n_step  = r_step;
        n_work  = r_work;
        n_quo   = r_quo;
        n_rem   = r_rem;
        unique case (r_state)
            ST_IDLE: begin
                if (i_push) begin
                    n_x     = i_item.pixel_x;
                    n_y     = i_item.pixel_y;
                    n_step  = i_item.step_ms;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_work  = {16'b0, r_step} * {16'b0, i_speed};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_work = {r_work[PHASE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                n_quo  = {r_quo[PHASE_W-DIGIT_W-1:0], dig.quo};
                n_rem  = dig.rem;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_phase = r_phase + r_quo;
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_job_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_x    <= n_x;
        r_y    <= n_y;
        r_step <= n_step;
        r_work <= n_work;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

    assign o_full        = (r_state != ST_IDLE);
    assign o_job_push    = (r_state == ST_PUSH) && !i_job_full;
    assign o_job.pixel_x = r_x;
    assign o_job.pixel_y = r_y;
    assign o_job.phase   = r_phase;

endmodule

/* hw/rtl/ppg_back.sv */
// Back end: phase divisions, three waves, average and tint for one job at a time.
// Uses ppg_pkg; pulls from the job queue and fills the result queue.
module ppg_back
    import ppg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    input  t_job              i_job,
    input  logic [TINT_W-1:0] i_tint,
    output logic              o_res_push,
    input  logic              i_res_full,
    output t_pixel_out        o_res
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WAVE = 3'd2;
    localparam logic [2:0] ST_AVG  = 3'd3;
    localparam logic [2:0] ST_TINT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [X_W-1:0]     r_x, n_x;
    logic [Y_W-1:0]     r_y, n_y;
    logic [PHASE_W-1:0] r_work, n_work;
    logic [REM_W-1:0]   r_rem_a, r_rem_b, r_rem_c, n_rem_a, n_rem_b, n_rem_c;
    logic [7:0]         r_q_a, r_q_b, r_q_c, n_q_a, n_q_b, n_q_c;
    logic [7:0]         r_w_a, r_w_b, r_w_c, n_w_a, n_w_b, n_w_c;
    logic [7:0]         r_avg, n_avg;
    logic [15:0]        r_pr, r_pg, r_pb, n_pr, n_pg, n_pb;
    t_div               dig_a, dig_b, dig_c;
    logic [7:0]         ang_a, ang_b, ang_c;
    logic [9:0]         wsum;
    logic [19:0]        avg_prod;

    assign dig_a = div_byte(r_rem_a, r_work[PHASE_W-1 -: DIGIT_W], DIV_A);
    assign dig_b = div_byte(r_rem_b, r_work[PHASE_W-1 -: DIGIT_W], DIV_B);
    assign dig_c = div_byte(r_rem_c, r_work[PHASE_W-1 -: DIGIT_W], DIV_C);

    // only the low byte of each quotient matters to the wave angle
    assign ang_a = {2'b0, r_x} * MUL_X + r_q_a;
    assign ang_b = {4'b0, r_y} * MUL_Y + r_q_b;
    assign ang_c = ({2'b0, r_x} + {4'b0, r_y}) * MUL_XY + r_q_c;

    assign wsum     = {2'b0, r_w_a} + {2'b0, r_w_b} + {2'b0, r_w_c};
    assign avg_prod = {10'b0, wsum} * {10'b0, AVG_MUL};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_work  = r_work;
        n_rem_a = r_rem_a;
        n_rem_b = r_rem_b;
        n_rem_c = r_rem_c;
        n_q_a   = r_q_a;
        n_q_b   = r_q_b;
        n_q_c   = r_q_c;
        n_w_a   = r_w_a;
        n_w_b   = r_w_b;
        n_w_c   = r_w_c;
        n_avg   = r_avg;
        n_pr    = r_pr;
        n_pg    = r_pg;
        n_pb    = r_pb;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_x     = i_job.pixel_x;
                    n_y     = i_job.pixel_y;
                    n_work  = i_job.phase;
                    n_rem_a = '0;
                    n_rem_b = '0;
                    n_rem_c = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_work  = {r_work[PHASE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                n_rem_a = dig_a.rem;
                n_rem_b = dig_b.rem;
                n_rem_c = dig_c.rem;
                n_q_a   = dig_a.quo;
                n_q_b   = dig_b.quo;
                n_q_c   = dig_c.quo;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_WAVE;
                end
            end
            ST_WAVE: begin
                n_w_a   = wave_at(ang_a);
                n_w_b   = wave_at(ang_b);
                n_w_c   = wave_at(ang_c);
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_avg   = avg_prod[AVG_SHIFT +: 8];
                n_state = ST_TINT;
            end
            ST_TINT: begin
                n_pr    = {8'b0, i_tint[23:16]} * {8'b0, r_avg};
                n_pg    = {8'b0, i_tint[15:8]} * {8'b0, r_avg};
                n_pb    = {8'b0, i_tint[7:0]} * {8'b0, r_avg};
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_x     <= n_x;
        r_y     <= n_y;
        r_work  <= n_work;
        r_rem_a <= n_rem_a;
        r_rem_b <= n_rem_b;
        r_rem_c <= n_rem_c;
        r_q_a   <= n_q_a;
        r_q_b   <= n_q_b;
        r_q_c   <= n_q_c;
        r_w_a   <= n_w_a;
        r_w_b   <= n_w_b;
        r_w_c   <= n_w_c;
        r_avg   <= n_avg;
        r_pr    <= n_pr;
        r_pg    <= n_pg;
        r_pb    <= n_pb;
    end

    assign o_job_pop   = (r_state == ST_IDLE) && !i_job_empty;
    assign o_res_push  = (r_state == ST_DONE) && !i_res_full;
    assign o_res.red   = div255(r_pr);
    assign o_res.green = div255(r_pg);
    assign o_res.blue  = div255(r_pb);

endmodule

/* hw/rtl/plasma_pixel_generator_top.sv */
// Plasma pixel generator, top level: APB register file, front, job queue, back, result queue.
// Depends on ppg_pkg, ppg_front, ppg_fifo and ppg_back.
//
// Each pixel pushed in (column, row, step in ms) gives one RGB result, in order.
// Before the pixel is drawn the step is scaled as step * speed / 50 and added to a
// wrapping 32-bit phase; send a nonzero step only with the first pixel of a frame.
// The front takes a pixel, multiplies and divides by 50 one byte per cycle and
// updates the phase; full stays high until the job is in the job queue, so the front
// takes no new pixel before it is through with the last. The back divides the phase by
// 9, 14 and 6 (one byte per cycle), evaluates the three waves, averages them and
// applies the tint, and pops no new job before its result is in the result queue.
// Its byte-wise phase division makes the back the slower half and so sets the pace.
// Small queues after the front and at the output let the host and the consumer stall
// independently.
// Registers (paddr[2] selects, low address bits ignored): 0x0 speed_percent
// (15:0, reset 50), 0x4 tint_color (23:0, reset 0xFF40FF, red 23:16, blue 7:0).
// Write registers only while no transfer is in flight inside the block.
module plasma_pixel_generator_top
    import ppg_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input side
    input  logic              push,
    output logic              full,
    input  t_pixel_in         i_pixel,
    // result queue side
    input  logic              pop,
    output logic              empty,
    output t_pixel_out        o_color,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [TINT_W-1:0]  r_tint, n_tint;
    logic               cfg_wr;

    logic       job_push, job_full, job_pop, job_empty;
    t_job       job_in, job_out;
    logic       res_push, res_full;
    t_pixel_out res_in;

    // ---- configuration registers; a transfer completes in the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_speed = r_speed;
        n_tint  = r_tint;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_SPEED: n_speed = pwdata[SPEED_W-1:0];
                REG_TINT:  n_tint  = pwdata[TINT_W-1:0];
                default:   n_speed = r_speed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
            r_tint  <= TINT_RESET;
        end else begin
            r_speed <= n_speed;
            r_tint  <= n_tint;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SPEED: prdata = {{(APB_DW-SPEED_W){1'b0}}, r_speed};
            REG_TINT:  prdata = {{(APB_DW-TINT_W){1'b0}}, r_tint};
            default:   prdata = '0;
        endcase
    end

    // ---- front: phase accumulation
    ppg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_pixel),
        .i_speed    (r_speed),
        .o_job_push (job_push),
        .i_job_full (job_full),
        .o_job      (job_in)
    );

    // ---- job queue between front and back
    ppg_fifo #(
        .DEPTH (JOB_DEPTH),
        .WIDTH ($bits(t_job))
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // ---- back: phase divisions, waves, average, tint
    ppg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .i_tint      (r_tint),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    // ---- result queue; head entry is shown while empty is low
    ppg_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_pixel_out))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_color),
        .o_empty (empty)
    );

endmodule
